[src/rcc_pkg.sv]
`default_nettype none
package rcc_pkg;

    // Widths of the accumulated sums and of the result
    localparam int SUM_BITS   = 64;
    localparam int LEVEL_BITS = 32;
    localparam int WORD_BITS  = 32;
    localparam int OUT_FRAC   = 16;

    // Numerator of the divide is diff_sum scaled by 2^(2*OUT_FRAC)
    localparam int NUM_BITS   = SUM_BITS + 2 * OUT_FRAC;
    localparam int DIV_STEPS  = NUM_BITS;
    localparam int SQRT_STEPS = SUM_BITS / 2;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    // Queue between the accumulator and the divide/sqrt unit
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_CONV_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_STEP_FLOOR    = 2'd1;
    localparam logic [1:0] CFG_REL_TOLERANCE = 2'd2;

    // Result classes
    localparam logic [1:0] CLASS_NORMAL    = 2'd0;
    localparam logic [1:0] CLASS_ZERO_DIFF = 2'd1;
    localparam logic [1:0] CLASS_INFINITE  = 2'd2;

    localparam logic [WORD_BITS-1:0] REL_MAX = {WORD_BITS{1'b1}};

    // One finished state: the two sums and the step number
    typedef struct packed {
        logic [SUM_BITS-1:0]   diff_sum;
        logic [SUM_BITS-1:0]   ref_sum;
        logic [LEVEL_BITS-1:0] level;
    } sums_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic                  conv_enable;
        logic [LEVEL_BITS-1:0] step_floor;
        logic [WORD_BITS-1:0]  rel_tolerance;
    } cfg_t;

endpackage
`default_nettype wire

[src/relative_change_convergence_top.sv]
`default_nettype none
// Relative L2 change of a streamed state against the previous one. Each input beat
// carries one (current, previous) velocity pair; the block accumulates the squared
// difference and the squared previous value in saturating 64-bit sums and accepts one
// pair per cycle. The beat marked last closes the state: one result beat follows with
// rel_change = floor(2^16 * sqrt(diff_sum / ref_sum)) saturated, the class (normal,
// zero difference, infinite) and the converged flag. A closed state is worked by a
// shift-subtract unit: a load step, the restoring divide, the square root and a
// hand-off to the output register, which waits while the output is stalled;
// zero-difference and zero-reference states skip divide and root. Up to two closed
// states wait in the queue; when two are pending in_stall rises until the back end
// takes one. Configuration writes are taken at any cycle (cfg_ready is always high)
// and must happen while idle.
module relative_change_convergence_top #(
    parameter int VALUE_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [31:0]                           cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [VALUE_BITS-1:0]          current_value,
    input  wire logic signed [VALUE_BITS-1:0]          previous_value,
    input  wire logic [31:0]                           step_level,
    input  wire logic                                  last,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [31:0]                                rel_change,
    output logic [1:0]                                 change_class,
    output logic                                       converged
);

    rcc_pkg::cfg_t                     cfg_reg;
    logic [rcc_pkg::SLOT_BITS-1:0]     slots_reg;
    logic                              accept;
    logic                              push;
    logic                              pop;
    logic                              not_empty;
    rcc_pkg::sums_t                    push_data;
    rcc_pkg::sums_t                    pop_data;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rcc_pkg::CFG_CONV_ENABLE:   cfg_reg.conv_enable   <= cfg_data[0];
                rcc_pkg::CFG_STEP_FLOOR:    cfg_reg.step_floor    <= cfg_data;
                rcc_pkg::CFG_REL_TOLERANCE: cfg_reg.rel_tolerance <= cfg_data;
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Credits: closed states in flight or queued, never more than the queue holds
    assign in_stall = (slots_reg == rcc_pkg::SLOT_BITS'(rcc_pkg::QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slots_reg <= '0;
        else
        begin
            case ({accept && last, pop})
                2'b10:   slots_reg <= slots_reg + 1'b1;
                2'b01:   slots_reg <= slots_reg - 1'b1;
                default: slots_reg <= slots_reg;
            endcase
        end
    end

    rcc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .current_value  (current_value),
        .previous_value (previous_value),
        .step_level     (step_level),
        .last           (last),
        .push           (push),
        .push_data      (push_data)
    );

    rcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    rcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .not_empty    (not_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rel_change   (rel_change),
        .change_class (change_class),
        .converged    (converged)
    );

endmodule
`default_nettype wire

[src/rcc_front.sv]
`default_nettype none
module rcc_front #(
    parameter int VALUE_BITS = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 accept,
    input  wire logic signed [VALUE_BITS-1:0]         current_value,
    input  wire logic signed [VALUE_BITS-1:0]         previous_value,
    input  wire logic [rcc_pkg::LEVEL_BITS-1:0]       step_level,
    input  wire logic                                 last,
    output logic                                      push,
    output rcc_pkg::sums_t                            push_data
);

    localparam int SQ_BITS = 2 * VALUE_BITS;

    logic signed [VALUE_BITS:0]          diff;
    logic [VALUE_BITS-1:0]               mag_d;
    logic [VALUE_BITS-1:0]               mag_p;

    logic                                s1_valid_reg;
    logic                                s1_last_reg;
    logic [rcc_pkg::LEVEL_BITS-1:0]      s1_level_reg;
    logic [VALUE_BITS-1:0]               s1_mag_d_reg;
    logic [VALUE_BITS-1:0]               s1_mag_p_reg;

    logic                                s2_valid_reg;
    logic                                s2_last_reg;
    logic [rcc_pkg::LEVEL_BITS-1:0]      s2_level_reg;
    logic [SQ_BITS-1:0]                  s2_sq_d_reg;
    logic [SQ_BITS-1:0]                  s2_sq_p_reg;

    logic [rcc_pkg::SUM_BITS-1:0]        diff_sum_reg;
    logic [rcc_pkg::SUM_BITS-1:0]        ref_sum_reg;
    logic [rcc_pkg::SUM_BITS-1:0]        diff_sum_next;
    logic [rcc_pkg::SUM_BITS-1:0]        ref_sum_next;
    logic [rcc_pkg::SUM_BITS:0]          diff_add;
    logic [rcc_pkg::SUM_BITS:0]          ref_add;

    // Stage 1: difference and magnitudes
    always_comb
    begin
        diff  = $signed({current_value[VALUE_BITS-1], current_value})
              - $signed({previous_value[VALUE_BITS-1], previous_value});
        mag_d = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : diff[VALUE_BITS-1:0];
        mag_p = previous_value[VALUE_BITS-1] ? VALUE_BITS'(-previous_value)
                                             : previous_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= last;
            s1_level_reg <= step_level;
            s1_mag_d_reg <= mag_d;
            s1_mag_p_reg <= mag_p;
        end
    end

    // Stage 2: squares
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_level_reg <= s1_level_reg;
            s2_sq_d_reg  <= SQ_BITS'(s1_mag_d_reg) * SQ_BITS'(s1_mag_d_reg);
            s2_sq_p_reg  <= SQ_BITS'(s1_mag_p_reg) * SQ_BITS'(s1_mag_p_reg);
        end
    end

    // Stage 3: saturating accumulate
    always_comb
    begin
        diff_add      = {1'b0, diff_sum_reg}
                      + (rcc_pkg::SUM_BITS + 1)'(s2_sq_d_reg);
        ref_add       = {1'b0, ref_sum_reg}
                      + (rcc_pkg::SUM_BITS + 1)'(s2_sq_p_reg);
        diff_sum_next = diff_add[rcc_pkg::SUM_BITS] ? {rcc_pkg::SUM_BITS{1'b1}}
                                                    : diff_add[rcc_pkg::SUM_BITS-1:0];
        ref_sum_next  = ref_add[rcc_pkg::SUM_BITS] ? {rcc_pkg::SUM_BITS{1'b1}}
                                                   : ref_add[rcc_pkg::SUM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_sum_reg <= '0;
            ref_sum_reg  <= '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                diff_sum_reg <= '0;
                ref_sum_reg  <= '0;
            end
            else
            begin
                diff_sum_reg <= diff_sum_next;
                ref_sum_reg  <= ref_sum_next;
            end
        end
    end

    // Finished state goes to the queue
    assign push               = s2_valid_reg & s2_last_reg;
    assign push_data.diff_sum = diff_sum_next;
    assign push_data.ref_sum  = ref_sum_next;
    assign push_data.level    = s2_level_reg;

endmodule
`default_nettype wire

[src/rcc_queue.sv]
`default_nettype none
module rcc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire rcc_pkg::sums_t  push_data,
    input  wire logic            pop,
    output logic                 not_empty,
    output rcc_pkg::sums_t       pop_data
);

    rcc_pkg::sums_t                   entry_reg [rcc_pkg::QUEUE_DEPTH];
    logic [rcc_pkg::PTR_BITS-1:0]     wr_ptr_reg;
    logic [rcc_pkg::PTR_BITS-1:0]     rd_ptr_reg;
    logic [rcc_pkg::SLOT_BITS-1:0]    count_reg;

    // Pointers and fill count; the credit count upstream keeps pushes off a full queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

endmodule
`default_nettype wire

[src/rcc_back.sv]
`default_nettype none
module rcc_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rcc_pkg::cfg_t                      cfg,
    input  wire logic                               not_empty,
    input  wire rcc_pkg::sums_t                     pop_data,
    output logic                                    pop,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [rcc_pkg::WORD_BITS-1:0]           rel_change,
    output logic [1:0]                              change_class,
    output logic                                    converged
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam int SB  = rcc_pkg::SUM_BITS;
    localparam int WB  = rcc_pkg::WORD_BITS;
    localparam int REM = WB + 2;

    state_t                           state_reg;
    state_t                           state_next;
    logic [rcc_pkg::CNT_BITS-1:0]     cnt_reg;
    logic [rcc_pkg::NUM_BITS-1:0]     num_reg;
    logic [SB-1:0]                    divisor_reg;
    logic [SB-1:0]                    drem_reg;
    logic [SB-1:0]                    quo_reg;
    logic                             ovf_reg;
    logic [REM-1:0]                   srem_reg;
    logic [WB-1:0]                    root_reg;
    logic [WB-1:0]                    rel_reg;
    logic [1:0]                       cls_reg;
    logic [rcc_pkg::LEVEL_BITS-1:0]   level_reg;

    logic                             out_valid_reg;
    logic [WB-1:0]                    rel_out_reg;
    logic [1:0]                       cls_out_reg;
    logic                             conv_out_reg;

    logic [SB:0]                      div_trial;
    logic                             div_ge;
    logic [SB-1:0]                    drem_next;
    logic [SB-1:0]                    quo_next;
    logic                             ovf_next;
    logic [REM+1:0]                   sq_trial;
    logic [REM+1:0]                   sq_sub;
    logic                             sq_ge;
    logic [WB-1:0]                    root_next;
    logic                             out_free;
    logic                             conv_calc;

    // One restoring divide step per cycle
    always_comb
    begin
        div_trial = {drem_reg, num_reg[rcc_pkg::NUM_BITS-1]};
        div_ge    = (div_trial >= {1'b0, divisor_reg});
        drem_next = div_ge ? SB'(div_trial - {1'b0, divisor_reg}) : div_trial[SB-1:0];
        quo_next  = {quo_reg[SB-2:0], div_ge};
        ovf_next  = ovf_reg | quo_reg[SB-1];
    end

    // One square root digit per cycle, radicand taken two bits at a time from quo_reg
    always_comb
    begin
        sq_trial  = {srem_reg, quo_reg[SB-1:SB-2]};
        sq_sub    = {2'b00, root_reg, 2'b01};
        sq_ge     = (sq_trial >= sq_sub);
        root_next = {root_reg[WB-2:0], sq_ge};
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && not_empty;
    assign conv_calc = cfg.conv_enable && (level_reg >= cfg.step_floor)
                       && (cls_reg != rcc_pkg::CLASS_INFINITE)
                       && (rel_reg < cfg.rel_tolerance);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    if (pop_data.diff_sum == '0 || pop_data.ref_sum == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == rcc_pkg::CNT_BITS'(rcc_pkg::DIV_STEPS - 1))
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cnt_reg == rcc_pkg::CNT_BITS'(rcc_pkg::SQRT_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                level_reg   <= pop_data.level;
                divisor_reg <= pop_data.ref_sum;
                num_reg     <= {pop_data.diff_sum, {(2 * rcc_pkg::OUT_FRAC){1'b0}}};
                drem_reg    <= '0;
                quo_reg     <= '0;
                ovf_reg     <= 1'b0;
                cnt_reg     <= '0;
                if (pop_data.diff_sum == '0)
                begin
                    rel_reg <= '0;
                    cls_reg <= rcc_pkg::CLASS_ZERO_DIFF;
                end
                else if (pop_data.ref_sum == '0)
                begin
                    rel_reg <= rcc_pkg::REL_MAX;
                    cls_reg <= rcc_pkg::CLASS_INFINITE;
                end
                else
                begin
                    cls_reg <= rcc_pkg::CLASS_NORMAL;
                end
            end
            ST_DIV:
            begin
                drem_reg <= drem_next;
                quo_reg  <= quo_next;
                ovf_reg  <= ovf_next;
                num_reg  <= {num_reg[rcc_pkg::NUM_BITS-2:0], 1'b0};
                srem_reg <= '0;
                root_reg <= '0;
                if (cnt_reg == rcc_pkg::CNT_BITS'(rcc_pkg::DIV_STEPS - 1))
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            ST_SQRT:
            begin
                srem_reg <= sq_ge ? REM'(sq_trial - sq_sub) : sq_trial[REM-1:0];
                root_reg <= root_next;
                quo_reg  <= {quo_reg[SB-3:0], 2'b00};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == rcc_pkg::CNT_BITS'(rcc_pkg::SQRT_STEPS - 1))
                    rel_reg <= ovf_reg ? rcc_pkg::REL_MAX : root_next;
            end
            ST_FIN:
            begin
                cnt_reg <= '0;
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_FIN && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            rel_out_reg  <= rel_reg;
            cls_out_reg  <= cls_reg;
            conv_out_reg <= conv_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rel_change   = rel_out_reg;
    assign change_class = cls_out_reg;
    assign converged    = conv_out_reg;

endmodule
`default_nettype wire

[tb/rcc_checker.sv]
`timescale 1ns / 1ps
// Watches the configuration, input and result channels of the relative change block.
// Keeps its own copy of the registers and the two running sums, works out the result
// of every closed state and compares each result beat with the oldest one pending.
module rcc_checker #(
    parameter int VALUE_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] current_value,
    input  logic signed [VALUE_BITS-1:0] previous_value,
    input  logic [31:0]                  step_level,
    input  logic                         last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [31:0]                  rel_change,
    input  logic [1:0]                   change_class,
    input  logic                         converged,
    output int                           pending,
    output int                           errors
);

    typedef struct packed {
        logic [31:0] rel;
        logic [1:0]  cls;
        logic        conv;
    } verdict_t;

    // Shadow registers and running sums
    logic                           enable_q    = 1'b0;
    logic [31:0]                    min_step_q  = '0;
    logic [31:0]                    tolerance_q = '0;
    logic [rcc_pkg::SUM_BITS-1:0]   diff_acc    = '0;
    logic [rcc_pkg::SUM_BITS-1:0]   ref_acc     = '0;
    verdict_t                       pending_verdicts[$];

    function automatic logic [rcc_pkg::SUM_BITS-1:0] square_mag(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic logic [rcc_pkg::SUM_BITS-1:0] add_sat(
        logic [rcc_pkg::SUM_BITS-1:0] a,
        logic [rcc_pkg::SUM_BITS-1:0] b);
        logic [rcc_pkg::SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rcc_pkg::SUM_BITS] ? {rcc_pkg::SUM_BITS{1'b1}} : s[rcc_pkg::SUM_BITS-1:0];
    endfunction

    // Largest root with root^2 * den <= num * 2^(2*OUT_FRAC), found bit by bit
    function automatic logic [31:0] scaled_root(logic [rcc_pkg::SUM_BITS-1:0] num,
                                                logic [rcc_pkg::SUM_BITS-1:0] den);
        logic [127:0] target;
        logic [127:0] den_w;
        logic [127:0] probe_w;
        logic [127:0] probe_sq;
        logic [31:0]  root;
        target = {64'b0, num} << (2 * rcc_pkg::OUT_FRAC);
        den_w  = {64'b0, den};
        root   = '0;
        for (int b = 31; b >= 0; b--)
        begin
            probe_w  = {96'b0, root | (32'd1 << b)};
            probe_sq = probe_w * probe_w * den_w;
            if (probe_sq <= target)
                root = probe_w[31:0];
        end
        return root;
    endfunction

    // Result of a closed state under the current registers
    function automatic verdict_t rel_change_of(logic [rcc_pkg::SUM_BITS-1:0] dsum,
                                               logic [rcc_pkg::SUM_BITS-1:0] rsum,
                                               logic [31:0]                  lvl);
        verdict_t v;
        if (dsum == 0)
        begin
            v.rel = '0;
            v.cls = rcc_pkg::CLASS_ZERO_DIFF;
        end
        else if (rsum == 0)
        begin
            v.rel = rcc_pkg::REL_MAX;
            v.cls = rcc_pkg::CLASS_INFINITE;
        end
        else
        begin
            v.rel = scaled_root(dsum, rsum);
            v.cls = rcc_pkg::CLASS_NORMAL;
        end
        v.conv = enable_q && (lvl >= min_step_q) && (v.cls != rcc_pkg::CLASS_INFINITE)
                 && (v.rel < tolerance_q);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            enable_q    <= 1'b0;
            min_step_q  <= '0;
            tolerance_q <= '0;
            diff_acc    = '0;
            ref_acc     = '0;
            pending_verdicts.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            // register writes; unknown index is dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rcc_pkg::CFG_CONV_ENABLE:   enable_q    <= cfg_data[0];
                    rcc_pkg::CFG_STEP_FLOOR:    min_step_q  <= cfg_data;
                    rcc_pkg::CFG_REL_TOLERANCE: tolerance_q <= cfg_data;
                    default: ;
                endcase
            end

            // result beat against oldest expectation
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result beat with nothing pending: rel_change %h", rel_change);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (rel_change !== want.rel)
                    begin
                        $error("rel_change: expected %h, got %h", want.rel, rel_change);
                        errors++;
                    end
                    if (change_class !== want.cls)
                    begin
                        $error("change_class: expected %0d, got %0d", want.cls, change_class);
                        errors++;
                    end
                    if (converged !== want.conv)
                    begin
                        $error("converged: expected %0d, got %0d", want.conv, converged);
                        errors++;
                    end
                end
            end

            // input beat: accumulate, close the state on last
            if (in_valid && !in_stall)
            begin
                diff_acc = add_sat(diff_acc, square_mag(longint'(current_value)
                                                        - longint'(previous_value)));
                ref_acc  = add_sat(ref_acc, square_mag(longint'(previous_value)));
                if (last)
                begin
                    pending_verdicts.push_back(rel_change_of(diff_acc, ref_acc, step_level));
                    diff_acc = '0;
                    ref_acc  = '0;
                end
            end

            pending = pending_verdicts.size();
        end
    end

endmodule

[tb/tb_relative_change_convergence_top.sv]
`timescale 1ns / 1ps
module tb_relative_change_convergence_top;

    localparam int      VALUE_BITS   = 24;
    localparam int      PAIR_TARGET  = 1800;
    localparam int      PHASE_PAIRS  = 300;
    localparam int      DRAIN_CYCLES = 200;
    localparam longint  CYCLE_LIMIT  = 3_000_000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // value mixes for one state
    typedef enum int {
        MIX_RANDOM,
        MIX_NEAR,
        MIX_SAME,
        MIX_NO_REF,
        MIX_HUGE,
        MIX_EXTREME
    } mix_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [1:0]                   cfg_index;
    logic [31:0]                  cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [VALUE_BITS-1:0] current_value;
    logic signed [VALUE_BITS-1:0] previous_value;
    logic [31:0]                  step_level;
    logic                         last;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [31:0]                  rel_change;
    logic [1:0]                   change_class;
    logic                         converged;

    int          in_flight;
    int          check_errors;
    int          pairs_sent = 0;
    logic [31:0] min_shadow = '0;
    int          stall_hold = 0;
    longint      cycle_count = 0;

    relative_change_convergence_top #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .current_value (current_value),
        .previous_value(previous_value),
        .step_level    (step_level),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rel_change    (rel_change),
        .change_class  (change_class),
        .converged     (converged)
    );

    rcc_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .current_value (current_value),
        .previous_value(previous_value),
        .step_level    (step_level),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rel_change    (rel_change),
        .change_class  (change_class),
        .converged     (converged),
        .pending       (in_flight),
        .errors        (check_errors)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_relative_change_convergence_top: errors");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // receiver back-pressure, with quiet stretches
    always @(negedge clk)
    begin
        if (stall_hold != 0)
            stall_hold--;
        else if ($urandom_range(0, 99) < 8)
        begin
            out_stall <= 1'b0;
            stall_hold = $urandom_range(50, 300);
        end
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold = pick_gap();
        end
    end

    function automatic logic [VALUE_BITS-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return '0;
            3:       return '1;
            default: return VALUE_BITS'(1);
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 30);
        return $urandom_range(31, 200);
    endfunction

    // step number for a closing beat, clustered around the step threshold
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return min_shadow;
            1:       return min_shadow - 32'd1;
            2:       return min_shadow + 32'($urandom_range(1, 1000));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == rcc_pkg::CFG_STEP_FLOOR)
            min_shadow = data;
    endtask

    // one input beat; returns at the falling edge after acceptance
    task automatic push_pair(input logic [VALUE_BITS-1:0] cur,
                             input logic [VALUE_BITS-1:0] prev,
                             input logic [31:0]           lvl,
                             input logic                  is_last,
                             input int                    gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        current_value  <= cur;
        previous_value <= prev;
        step_level     <= lvl;
        last           <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        pairs_sent++;
    endtask

    task automatic one_state(input logic [VALUE_BITS-1:0] cur,
                             input logic [VALUE_BITS-1:0] prev,
                             input logic [31:0]           lvl);
        push_pair(cur, prev, lvl, 1'b1, pick_gap());
    endtask

    // wait until every result is back and the back end has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_state(input mix_t mix, input int len, input bit bursty);
        logic [VALUE_BITS-1:0] c;
        logic [VALUE_BITS-1:0] p;
        logic [31:0]           lvl;
        for (int k = 0; k < len; k++)
        begin
            p = VALUE_BITS'($urandom);
            c = VALUE_BITS'($urandom);
            case (mix)
                MIX_NEAR:    c = p + VALUE_BITS'($urandom_range(0, 511)) - VALUE_BITS'(256);
                MIX_SAME:    c = p;
                MIX_NO_REF:  p = '0;
                MIX_HUGE:    p = VALUE_BITS'($urandom_range(0, 2)) - VALUE_BITS'(1);
                MIX_EXTREME:
                begin
                    c = corner_value();
                    p = corner_value();
                end
                default: ;
            endcase
            lvl = (k == len - 1) ? pick_level() : $urandom;
            push_pair(c, p, lvl, k == len - 1, bursty ? 0 : pick_gap());
        end
    endtask

    task automatic shuffle_config();
        logic [31:0] tol;
        logic [31:0] min_val;
        case ($urandom_range(0, 4))
            0:       tol = '0;
            1:       tol = '1;
            2:       tol = $urandom_range(0, 64);
            3:       tol = $urandom_range(0, 1 << 18);
            default: tol = $urandom;
        endcase
        case ($urandom_range(0, 2))
            0:       min_val = '0;
            1:       min_val = '1;
            default: min_val = $urandom;
        endcase
        write_reg(rcc_pkg::CFG_CONV_ENABLE, 32'($urandom_range(0, 3) != 0));
        write_reg(rcc_pkg::CFG_STEP_FLOOR, min_val);
        write_reg(rcc_pkg::CFG_REL_TOLERANCE, tol);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, $urandom);
    endtask

    initial
    begin
        mix_t mix;
        int   r;
        int   phase_end;

        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        current_value  = '0;
        previous_value = '0;
        step_level     = '0;
        last           = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: decision disabled; class corners and field extremes
        one_state(VALUE_BITS'(1234), VALUE_BITS'(1234), '0);   // zero difference
        one_state('0, '0, '0);                                 // zero difference, zero reference
        one_state(VALUE_BITS'(100), '0, '0);                   // zero reference, infinite
        one_state(V_MAX, VALUE_BITS'(1), '0);                  // ratio saturates
        push_pair(V_MAX, V_MIN, $urandom, 1'b0, pick_gap());
        push_pair(V_MIN, V_MAX, '1, 1'b1, pick_gap());
        push_pair(VALUE_BITS'(-5), VALUE_BITS'(-3), $urandom, 1'b0, pick_gap());
        push_pair(VALUE_BITS'(7), VALUE_BITS'(9), $urandom, 1'b0, pick_gap());
        push_pair(VALUE_BITS'(300), VALUE_BITS'(280), '0, 1'b1, pick_gap());
        drain();

        // enabled with zero tolerance: never converged
        write_reg(rcc_pkg::CFG_CONV_ENABLE, 32'd1);
        write_reg(rcc_pkg::CFG_STEP_FLOOR, '0);
        write_reg(rcc_pkg::CFG_REL_TOLERANCE, '0);
        one_state(VALUE_BITS'(1001), VALUE_BITS'(1000), '0);
        one_state(VALUE_BITS'(5), VALUE_BITS'(5), '0);
        drain();

        // full tolerance, step threshold around 5
        write_reg(rcc_pkg::CFG_STEP_FLOOR, 32'd5);
        write_reg(rcc_pkg::CFG_REL_TOLERANCE, '1);
        one_state(VALUE_BITS'(1001), VALUE_BITS'(1000), 32'd4);
        one_state(VALUE_BITS'(1001), VALUE_BITS'(1000), 32'd5);
        one_state(VALUE_BITS'(7), '0, 32'd9);
        one_state(VALUE_BITS'(5), VALUE_BITS'(5), 32'd5);
        drain();

        // top step threshold; unused index must not disturb anything
        write_reg(rcc_pkg::CFG_STEP_FLOOR, '1);
        write_reg(CFG_UNUSED, '1);
        one_state(VALUE_BITS'(1001), VALUE_BITS'(1000), 32'hFFFF_FFFE);
        one_state(VALUE_BITS'(1001), VALUE_BITS'(1000), '1);
        drain();

        // random phases, new register setting each
        pairs_sent = 0;
        while (pairs_sent < PAIR_TARGET)
        begin
            shuffle_config();
            phase_end = pairs_sent + PHASE_PAIRS;
            while (pairs_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    mix = MIX_RANDOM;
                else if (r < 60)
                    mix = MIX_NEAR;
                else if (r < 70)
                    mix = MIX_SAME;
                else if (r < 78)
                    mix = MIX_NO_REF;
                else if (r < 88)
                    mix = MIX_HUGE;
                else
                    mix = MIX_EXTREME;
                send_state(mix, pick_len(), $urandom_range(0, 3) == 0);
            end
            drain();
        end

        if (check_errors == 0)
            $display("tb_relative_change_convergence_top: clean");
        else
            $display("tb_relative_change_convergence_top: errors");
        $finish;
    end

endmodule

[filelist.f]
src/rcc_pkg.sv
src/rcc_front.sv
src/rcc_queue.sv
src/rcc_back.sv
src/relative_change_convergence_top.sv
tb/rcc_checker.sv
tb/tb_relative_change_convergence_top.sv
